@@ src/sensor_frame_parser_sum_check_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sensor frame parser
// Shared wrappers that clock on clk and sleep while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SENSOR_FRAME_PARSER_SUM_CHECK_CORE_ASSERT_SVH
`define SENSOR_FRAME_PARSER_SUM_CHECK_CORE_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define SFPSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define SFPSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/sfpsc_pkg.sv @@
// ----------------------------------------------------------------------------
// sfpsc_pkg
// Constants and types shared by the sensor frame parser modules.
// ----------------------------------------------------------------------------
package sfpsc_pkg;

  // Payload bytes per frame (valid range 6 to 16) and bytes kept for output
  localparam int unsigned PAYLOAD_BYTES = 8;
  localparam int unsigned KEPT_BYTES    = 6;

  localparam int unsigned CNT_W      = $clog2(PAYLOAD_BYTES);
  localparam int unsigned KEPT_IDX_W = $clog2(KEPT_BYTES);

  localparam logic [CNT_W-1:0] LAST_IDX   = CNT_W'(PAYLOAD_BYTES - 1);
  localparam logic [CNT_W-1:0] KEPT_LIMIT = CNT_W'(KEPT_BYTES);

  // Frame header and checksum bias
  localparam logic [7:0] HDR0     = 8'h16;
  localparam logic [7:0] HDR1     = 8'h09;
  localparam logic [7:0] HDR2     = 8'h01;
  localparam logic [7:0] SUM_BIAS = 8'h20;

  typedef enum logic [4:0] {
    PH_HDR0  = 5'b00001,
    PH_HDR1  = 5'b00010,
    PH_HDR2  = 5'b00100,
    PH_DATA  = 5'b01000,
    PH_CHECK = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [15:0] concentration;
    logic [15:0] flow;
    logic [15:0] temperature;
    logic        checksum_ok;
  } sfpsc_result_t;

endpackage

@@ src/sfpsc_if.sv @@
// ----------------------------------------------------------------------------
// sfpsc channel interfaces
// Valid/ready channels for received bytes and for decoded frame results.
// ----------------------------------------------------------------------------
interface sfpsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfpsc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] concentration;
  logic [15:0] flow;
  logic [15:0] temperature;
  logic        checksum_ok;

  modport source (output valid, output concentration, output flow,
                  output temperature, output checksum_ok, input ready);
  modport sink   (input valid, input concentration, input flow,
                  input temperature, input checksum_ok, output ready);
endinterface

@@ src/sfpsc_parser.sv @@
// ----------------------------------------------------------------------------
// sfpsc_parser
// Frame state machine: header hunt, payload capture, running sum, check.
// ----------------------------------------------------------------------------
`include "sensor_frame_parser_sum_check_core_assert.svh"

module sfpsc_parser
  import sfpsc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic [7:0]    rx_byte,
  output logic          res_valid,
  output sfpsc_result_t result
);

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [7:0]       running_sum_r, running_sum_nxt;
  logic [7:0]       payload_r [KEPT_BYTES];
  logic [7:0]       expect_sum;
  logic             store_en;

  assign expect_sum = 8'h00 - SUM_BIAS - running_sum_r;
  assign res_valid  = (phase_r == PH_CHECK);
  assign store_en   = step && (phase_r == PH_DATA) && (byte_count_r < KEPT_LIMIT);

  assign result.concentration = {payload_r[0], payload_r[1]};
  assign result.flow          = {payload_r[2], payload_r[3]};
  assign result.temperature   = {payload_r[4], payload_r[5]};
  assign result.checksum_ok   = (rx_byte == expect_sum);

  always_comb begin
    phase_nxt       = phase_r;
    byte_count_nxt  = byte_count_r;
    running_sum_nxt = running_sum_r;
    if (step) begin
      unique case (phase_r)
        PH_HDR0: begin
          if (rx_byte == HDR0) phase_nxt = PH_HDR1;
        end
        PH_HDR1: begin
          phase_nxt = (rx_byte == HDR1) ? PH_HDR2 : PH_HDR0;
        end
        PH_HDR2: begin
          if (rx_byte == HDR2) begin
            phase_nxt       = PH_DATA;
            byte_count_nxt  = '0;
            running_sum_nxt = '0;
          end else begin
            phase_nxt = PH_HDR0;
          end
        end
        PH_DATA: begin
          running_sum_nxt = running_sum_r + rx_byte;
          if (byte_count_r == LAST_IDX) begin
            phase_nxt      = PH_CHECK;
            byte_count_nxt = '0;
          end else begin
            byte_count_nxt = byte_count_r + CNT_W'(1);
          end
        end
        PH_CHECK: begin
          phase_nxt       = PH_HDR0;
          byte_count_nxt  = '0;
          running_sum_nxt = '0;
        end
        default: begin
          phase_nxt       = PH_HDR0;
          byte_count_nxt  = '0;
          running_sum_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HDR0;
      byte_count_r  <= '0;
      running_sum_r <= '0;
    end else begin
      phase_r       <= phase_nxt;
      byte_count_r  <= byte_count_nxt;
      running_sum_r <= running_sum_nxt;
    end
  end

  // Kept payload bytes: each is rewritten in every frame before it is read
  always_ff @(posedge clk) begin
    if (store_en) begin
      payload_r[byte_count_r[KEPT_IDX_W-1:0]] <= rx_byte;
    end
  end

  `SFPSC_ASSERT_NEXT(a_hdr_done_clears,
    step && (phase_r == PH_HDR2) && (rx_byte == HDR2),
    (phase_r == PH_DATA) && (byte_count_r == '0) && (running_sum_r == '0),
    "header match did not start a clean payload")
  `SFPSC_ASSERT_NEXT(a_check_returns,
    step && (phase_r == PH_CHECK),
    (phase_r == PH_HDR0) && (running_sum_r == '0),
    "checksum byte did not return to header hunt")
  `SFPSC_ASSERT_NEXT(a_hold_when_idle,
    !step,
    $stable(phase_r) && $stable(running_sum_r) && $stable(byte_count_r),
    "parser state moved without a byte")

endmodule

@@ src/sensor_frame_parser_sum_check_core.sv @@
// ----------------------------------------------------------------------------
// sensor_frame_parser_sum_check_core
// Sensor frame parser with additive checksum, up to one received byte per cycle.
// ----------------------------------------------------------------------------
// The core takes up to one received byte per clock on in_ch and, for every frame
// 16 09 01 <8 payload bytes> <checksum>, returns one transaction on out_ch
// carrying concentration, flow and temperature (big-endian payload bytes 0-1,
// 2-3 and 4-5) and checksum_ok, set when the checksum byte equals
// (0 - (0x20 + payload sum)) mod 256. Values are returned even when the
// checksum fails; payload bytes 6 and 7 only enter the sum. A wrong second or
// third header byte is dropped and the hunt restarts on the following byte.
// Rate: one byte per cycle unless stalled as told below. A byte is held in an
// input register and decoded by the state machine from there, and the result
// of a frame is registered in the output register when its checksum byte is
// decoded, and is then offered on out_ch. in_ch.ready falls only while a
// checksum byte waits in the input register and the output register still
// holds a result that out_ch has not taken; reset leaves no state to sweep.
// ----------------------------------------------------------------------------
`include "sensor_frame_parser_sum_check_core_assert.svh"

module sensor_frame_parser_sum_check_core
  import sfpsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  sfpsc_in_if.sink           in_ch,
  sfpsc_out_if.source        out_ch
);

  // Input register
  logic          in_vld_r;
  logic [7:0]    in_byte_r;
  // Output register
  logic          out_vld_r, out_vld_nxt;
  sfpsc_result_t out_res_r;

  logic          adv;
  logic          res_valid;
  sfpsc_result_t result;

  // Advance the held byte unless it makes a result with nowhere to go
  assign adv = in_vld_r && (!res_valid || !out_vld_r || out_ch.ready);

  assign in_ch.ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.rx_byte;
    end
  end

  sfpsc_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .rx_byte   (in_byte_r),
    .res_valid (res_valid),
    .result    (result)
  );

  // Load a fresh result; otherwise hold until the sink takes it
  assign out_vld_nxt = (adv && res_valid) || (out_vld_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      out_res_r <= result;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.concentration = out_res_r.concentration;
  assign out_ch.flow          = out_res_r.flow;
  assign out_ch.temperature   = out_res_r.temperature;
  assign out_ch.checksum_ok   = out_res_r.checksum_ok;

  `SFPSC_ASSERT_NEXT(a_in_hold,
    in_vld_r && !adv,
    in_vld_r && $stable(in_byte_r),
    "stalled input byte was lost or changed")
  `SFPSC_ASSERT_NEXT(a_result_loaded,
    adv && res_valid,
    out_vld_r,
    "frame result not loaded into output register")
  `SFPSC_ASSERT_NOW(a_no_overwrite,
    adv && res_valid && out_vld_r,
    out_ch.ready,
    "pending result overwritten")

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Sensor frame parser regression
// Streams well-formed and broken sensor frames into the parser byte by byte.
// A scoreboard tracks the header hunt, payload capture and checksum, and
// every decoded frame that leaves the core is compared against that view.
// ----------------------------------------------------------------------------
module testbench;
  import sfpsc_pkg::*;

  logic clk = 1'b0;
  logic rst_n;

  sfpsc_in_if  rx_link();
  sfpsc_out_if frame_link();

  sensor_frame_parser_sum_check_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (rx_link),
    .out_ch (frame_link)
  );

  always #4 clk = ~clk;

  // Bytes waiting to go out on the receive channel, and the decoded frames
  // that the scoreboard still expects to see.
  logic [7:0]    rx_pending[$];
  sfpsc_result_t frames_due[$];

  // Scoreboard view of the parser.
  phase_t      hunt_phase;
  int unsigned body_count;
  logic [7:0]  body_sum;
  logic [7:0]  kept_bytes [KEPT_BYTES];

  // Scratch payload for building frames.
  logic [7:0]  frame_body [PAYLOAD_BYTES];

  // Idle limits per side, changed between stages of the run.
  int          rx_gap_max;
  int          frame_stall_max;

  int          rx_gap_left;
  int          frame_stall_left;

  int          bytes_queued;
  int          bytes_accepted;
  int          frame_bytes;
  int          frames_checked;
  int          frames_good_sum;
  int          mismatches;

  // Track the parser over one accepted byte; queue a decoded frame when the
  // checksum byte lands.
  function automatic void parse_rx_byte(input logic [7:0] b);
    sfpsc_result_t decoded;
    logic [7:0]    want;
    case (hunt_phase)
      PH_HDR0: begin
        if (b == HDR0) hunt_phase = PH_HDR1;
      end
      PH_HDR1: begin
        // a wrong second byte is dropped outright, not retried as a header start
        hunt_phase = (b == HDR1) ? PH_HDR2 : PH_HDR0;
      end
      PH_HDR2: begin
        if (b == HDR2) begin
          hunt_phase = PH_DATA;
          body_count = 0;
          body_sum   = 8'h00;
        end else begin
          hunt_phase = PH_HDR0;
        end
      end
      PH_DATA: begin
        // bytes past the kept window only feed the sum
        if (body_count < KEPT_BYTES) kept_bytes[body_count] = b;
        body_sum   = body_sum + b;
        body_count = body_count + 1;
        if (body_count >= PAYLOAD_BYTES) begin
          hunt_phase = PH_CHECK;
          body_count = 0;
        end
      end
      PH_CHECK: begin
        want = 8'h00 - SUM_BIAS - body_sum;
        decoded.concentration = {kept_bytes[0], kept_bytes[1]};
        decoded.flow          = {kept_bytes[2], kept_bytes[3]};
        decoded.temperature   = {kept_bytes[4], kept_bytes[5]};
        decoded.checksum_ok   = (b == want);
        frames_due.push_back(decoded);
        if (decoded.checksum_ok) frames_good_sum++;
        hunt_phase = PH_HDR0;
        body_count = 0;
        body_sum   = 8'h00;
      end
      default: begin
        hunt_phase = PH_HDR0;
        body_count = 0;
        body_sum   = 8'h00;
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Receive-side driver: offer one byte per transaction, with a random gap
  // drawn as each byte is offered and spent before the next one. A byte held against a low ready stays put.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_link.valid   <= 1'b0;
      rx_link.rx_byte <= 8'h00;
      rx_gap_left     <= 0;
    end else begin
      if (rx_link.valid && rx_link.ready) begin
        parse_rx_byte(rx_link.rx_byte);
        bytes_accepted++;
      end
      // advance only when no byte is left waiting on the channel
      if (!rx_link.valid || rx_link.ready) begin
        if (rx_gap_left > 0) begin
          rx_link.valid <= 1'b0;
          rx_gap_left   <= rx_gap_left - 1;
        end else if (rx_pending.size() != 0) begin
          rx_link.valid   <= 1'b1;
          rx_link.rx_byte <= rx_pending.pop_front();
          rx_gap_left     <= $urandom_range(0, rx_gap_max);
        end else begin
          rx_link.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result-side monitor: take each frame transaction, compare it field by
  // field with the oldest expectation, then stall ready for a random spell.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    sfpsc_result_t want;
    int            stall;
    if (!rst_n) begin
      frame_link.ready <= 1'b0;
      frame_stall_left <= 0;
    end else begin
      if (frame_link.valid && frame_link.ready) begin
        if (frames_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected frame: conc=%h flow=%h temp=%h ok=%b",
                     frame_link.concentration, frame_link.flow,
                     frame_link.temperature, frame_link.checksum_ok);
        end else begin
          want = frames_due.pop_front();
          frames_checked++;
          if (frame_link.concentration !== want.concentration ||
              frame_link.flow          !== want.flow          ||
              frame_link.temperature   !== want.temperature   ||
              frame_link.checksum_ok   !== want.checksum_ok) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("frame mismatch: exp conc=%h flow=%h temp=%h ok=%b, ",
                     want.concentration, want.flow, want.temperature,
                     want.checksum_ok);
              $display("got conc=%h flow=%h temp=%h ok=%b",
                       frame_link.concentration, frame_link.flow,
                       frame_link.temperature, frame_link.checksum_ok);
            end
          end
        end
        // draw the stall before the next frame is taken; zero keeps ready up
        stall = $urandom_range(0, frame_stall_max);
        frame_stall_left <= (stall > 0) ? stall - 1 : 0;
        frame_link.ready <= (stall == 0);
      end else if (frame_stall_left > 0) begin
        frame_stall_left <= frame_stall_left - 1;
        frame_link.ready <= 1'b0;
      end else begin
        frame_link.ready <= 1'b1;
      end
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    rx_pending.push_back(b);
    bytes_queued++;
  endtask

  // Queue header, the payload in frame_body and a checksum, good or corrupted.
  task automatic queue_frame(input bit sum_good);
    logic [7:0] total;
    logic [7:0] check_byte;
    total = 8'h00;
    queue_byte(HDR0);
    queue_byte(HDR1);
    queue_byte(HDR2);
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      queue_byte(frame_body[i]);
      total = total + frame_body[i];
    end
    check_byte = 8'h00 - SUM_BIAS - total;
    if (!sum_good) check_byte = check_byte + 8'($urandom_range(1, 255));
    queue_byte(check_byte);
    frame_bytes += PAYLOAD_BYTES + 4;
  endtask

  // Hold until every queued byte is taken and every frame has come back.
  task automatic drain_link();
    while (bytes_accepted != bytes_queued || frames_due.size() != 0)
      @(posedge clk);
    // let the last byte clear the pipeline
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int         pick;
    int         target;
    int         body_mode;
    logic [7:0] stray;

    rx_link.valid      = 1'b0;
    rx_link.rx_byte    = 8'h00;
    frame_link.ready   = 1'b0;
    rst_n              = 1'b0;
    hunt_phase         = PH_HDR0;
    body_count         = 0;
    body_sum           = 8'h00;
    foreach (kept_bytes[i]) kept_bytes[i] = 8'h00;
    rx_gap_max         = 3;
    frame_stall_max    = 3;
    bytes_queued       = 0;
    bytes_accepted     = 0;
    frame_bytes        = 0;
    frames_checked     = 0;
    frames_good_sum    = 0;
    mismatches         = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: a wrong second header byte swallows a would-be header start,
    // so this run of bytes must not open a frame.
    queue_byte(HDR0);
    queue_byte(HDR0);
    queue_byte(HDR1);
    queue_byte(HDR2);
    // all-ones payload with a good checksum
    foreach (frame_body[i]) frame_body[i] = 8'hFF;
    queue_frame(1'b1);
    // wrong third header byte
    queue_byte(HDR0);
    queue_byte(HDR1);
    queue_byte(HDR0);
    // all-zero payload with a broken checksum
    foreach (frame_body[i]) frame_body[i] = 8'h00;
    queue_frame(1'b0);

    // pause the sender until every frame so far has been returned
    drain_link();

    // Random: mostly well-formed frames, with noise and broken headers mixed in.
    for (int stage = 0; stage < 4; stage++) begin
      case (stage)
        0: begin rx_gap_max = 0;  frame_stall_max = 0;  end
        1: begin rx_gap_max = 15; frame_stall_max = 15; end
        2: begin rx_gap_max = 0;  frame_stall_max = 15; end
        default: begin rx_gap_max = 15; frame_stall_max = 0; end
      endcase
      target = frame_bytes + 400;
      while (frame_bytes < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          body_mode = $urandom_range(0, 7);
          foreach (frame_body[i])
            frame_body[i] = (body_mode == 0) ? 8'h00 :
                            (body_mode == 1) ? 8'hFF : 8'($urandom_range(0, 255));
          queue_frame($urandom_range(0, 9) < 7);
        end else if (pick < 85) begin
          repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(0, 255)));
        end else if (pick < 95) begin
          // header that breaks on its second or third byte
          queue_byte(HDR0);
          stray = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 1)) begin
            queue_byte(HDR1);
            if (stray == HDR2) stray = HDR0;
          end else begin
            if (stray == HDR1) stray = HDR0;
          end
          queue_byte(stray);
        end else begin
          // truncated frame: later bytes get folded into its payload
          queue_byte(HDR0);
          queue_byte(HDR1);
          queue_byte(HDR2);
          repeat ($urandom_range(1, PAYLOAD_BYTES - 1))
            queue_byte(8'($urandom_range(0, 255)));
        end
      end
      // finish this stage under its own idle limits before the next one
      drain_link();
    end

    drain_link();

    if (frames_due.size() != 0) begin
      mismatches += frames_due.size();
      $display("%0d frames expected but never returned", frames_due.size());
    end

    $write("Summary: %0d bytes streamed, %0d frames decoded ",
           bytes_accepted, frames_checked);
    $display("(%0d good checksum, %0d bad)",
             frames_good_sum, frames_checked - frames_good_sum);
    $display("Summary: %0d mismatches over four idle/stall stages", mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #3200000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/sfpsc_pkg.sv
src/sfpsc_if.sv
src/sfpsc_parser.sv
src/sensor_frame_parser_sum_check_core.sv
tb/testbench.sv
